// ===== rtl/quintic_hermite_eval_defines.svh =====
// ---------------------------------------------------------------------------
// quintic hermite evaluator assertion macros
// concurrent assertion wrappers, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef QUINTIC_HERMITE_EVAL_DEFINES_SVH
`define QUINTIC_HERMITE_EVAL_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled in reset
`define QHE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qhe assertion failed");
// next-cycle implication, disabled in reset
`define QHE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qhe assertion failed");
`else
`define QHE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define QHE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/qhe_pkg.sv =====
// ---------------------------------------------------------------------------
// qhe_pkg
// shared constants for the quintic hermite curve evaluator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qhe_pkg;

  // default coordinate width (signed, 16 fraction bits)
  localparam int COORD_WIDTH_DEF = 24;

  // parameter t, unsigned q0.16 with one extra bit for 1.0
  localparam int T_W = 17;
  localparam logic [T_W-1:0] T_ONE = 17'd65536;

  // basis weight width, q.17 signed
  localparam int WEIGHT_W = 28;

  // output component width
  localparam int OUT_W = 32;

  // derivative order codes
  localparam logic [1:0] ORDER_POS  = 2'd0;
  localparam logic [1:0] ORDER_D1   = 2'd1;
  localparam logic [1:0] ORDER_D2   = 2'd2;
  localparam logic [1:0] ORDER_NONE = 2'd3;

  // configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_START_POINT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_END_POINT     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_TANGENT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_END_TANGENT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_START_SECOND  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_END_SECOND    = 3'd5;

  // next power of t, q0.16 rounded half up
  function automatic logic [T_W-1:0] pow_step(input logic [T_W-1:0] a,
                                              input logic [T_W-1:0] t);
    logic [2*T_W-1:0] p;
    p = ({{T_W{1'b0}}, a} * {{T_W{1'b0}}, t}) + (2*T_W)'(32768);
    return p[16 +: T_W];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/qhe_cfg_if.sv =====
// ---------------------------------------------------------------------------
// qhe_cfg_if
// configuration write channel: register index and packed x,y data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qhe_cfg_if
  import qhe_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic [REG_IDX_W-1:0]     index;
  logic [2*COORD_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/qhe_sample_if.sv =====
// ---------------------------------------------------------------------------
// qhe_sample_if
// input channel: derivative order and curve parameter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qhe_sample_if
  import qhe_pkg::*;
;
  logic           valid;
  logic           ready;
  logic [1:0]     func;
  logic [T_W-1:0] param_t;

  modport source (output valid, output func, output param_t, input ready);
  modport sink   (input valid, input func, input param_t, output ready);
endinterface

`default_nettype wire

// ===== rtl/qhe_result_if.sv =====
// ---------------------------------------------------------------------------
// qhe_result_if
// output channel: saturated q16.16 x and y components
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qhe_result_if
  import qhe_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_x;
  logic signed [OUT_W-1:0] out_y;

  modport source (output valid, output out_x, output out_y, input ready);
  modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/quintic_hermite_eval.sv =====
// Throughput: one transaction per cycle while result.ready holds no stage back,
// set by the ten-stage pipeline with a per-stage hold that fills bubbles.
// Reset (rst, synchronous) clears all stage valid bits and the six curve
// registers to zero; configuration writes are taken every cycle.
// ---------------------------------------------------------------------------
// quintic_hermite_eval
// pipelined 2d quintic hermite curve evaluator (position, 1st, 2nd deriv)
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "quintic_hermite_eval_defines.svh"

module quintic_hermite_eval
  import qhe_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire          clk,
  input  wire          rst,
  qhe_cfg_if.sink      cfg,
  qhe_sample_if.sink   sample,
  qhe_result_if.source result
);

  localparam int NSTG   = 10;
  localparam int PROD_W = WEIGHT_W + COORD_WIDTH;
  localparam int SUM_W  = PROD_W + 3;
  localparam logic signed [SUM_W-1:0] SAT_HI  = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_LO  = SUM_W'(-64'sd2147483648);
  localparam logic signed [SUM_W-1:0] RND_ADD = SUM_W'(64'sd65536);

  // curve registers
  logic [2*COORD_WIDTH-1:0] vec [6];

  // stage control
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  // power stages
  logic [T_W-1:0] t1_a;
  logic [1:0]     f_a;
  logic [T_W-1:0] t1_b, t2_b;
  logic [1:0]     f_b;
  logic [T_W-1:0] t1_c, t2_c, t3_c;
  logic [1:0]     f_c;
  logic [T_W-1:0] t1_d, t2_d, t3_d, t4_d;
  logic [1:0]     f_d;
  logic [T_W-1:0] t1_e, t2_e, t3_e, t4_e, t5_e;
  logic [1:0]     f_e;

  // weight, product and sum stages
  logic signed [WEIGHT_W-1:0] w      [6];
  logic signed [WEIGHT_W-1:0] w_next [6];
  logic signed [PROD_W-1:0]   px     [6];
  logic signed [PROD_W-1:0]   py     [6];
  logic signed [SUM_W-1:0]    hx     [3];
  logic signed [SUM_W-1:0]    hy     [3];
  logic signed [SUM_W-1:0]    sx, sy;
  logic signed [OUT_W-1:0]    ox, oy;

  logic [T_W-1:0] t_clamp;
  logic signed [SUM_W-1:0] qx, qy;

  // configuration writes, indexes beyond the list are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) vec[i] <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_START_POINT:   vec[0] <= cfg.data;
        REG_END_POINT:     vec[1] <= cfg.data;
        REG_START_TANGENT: vec[2] <= cfg.data;
        REG_END_TANGENT:   vec[3] <= cfg.data;
        REG_START_SECOND:  vec[4] <= cfg.data;
        REG_END_SECOND:    vec[5] <= cfg.data;
        default: ;
      endcase
    end
  end

  // per-stage hold: a stage loads when it is empty or its successor moves
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || result.ready;
    for (int i = NSTG-2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign sample.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= sample.valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // clamp t to one
  assign t_clamp = (sample.param_t > T_ONE) ? T_ONE : sample.param_t;

  // powers of t, one multiply in each stage after the first
  always_ff @(posedge clk) begin
    if (en[0]) begin
      t1_a <= t_clamp;
      f_a  <= sample.func;
    end
    if (en[1]) begin
      t1_b <= t1_a;
      t2_b <= pow_step(t1_a, t1_a);
      f_b  <= f_a;
    end
    if (en[2]) begin
      t1_c <= t1_b;
      t2_c <= t2_b;
      t3_c <= pow_step(t2_b, t1_b);
      f_c  <= f_b;
    end
    if (en[3]) begin
      t1_d <= t1_c;
      t2_d <= t2_c;
      t3_d <= t3_c;
      t4_d <= pow_step(t3_c, t1_c);
      f_d  <= f_c;
    end
    if (en[4]) begin
      t1_e <= t1_d;
      t2_e <= t2_d;
      t3_e <= t3_d;
      t4_e <= t4_d;
      t5_e <= pow_step(t4_d, t1_d);
      f_e  <= f_d;
    end
  end

  // basis weights at twice their value, vector order p0 d1_0 d2_0 d2_1 d1_1 p1
  always_comb begin
    logic signed [31:0] e1, e2, e3, e4, e5, one;
    e1  = $signed({15'b0, t1_e});
    e2  = $signed({15'b0, t2_e});
    e3  = $signed({15'b0, t3_e});
    e4  = $signed({15'b0, t4_e});
    e5  = $signed({15'b0, t5_e});
    one = $signed({15'b0, T_ONE});
    unique case (f_e)
      ORDER_POS: begin
        w_next[0] = WEIGHT_W'(2 * (-6 * e5 + 15 * e4 - 10 * e3) + 2 * one);
        w_next[1] = WEIGHT_W'(2 * (-3 * e5 + 8 * e4 - 6 * e3 + e1));
        w_next[2] = WEIGHT_W'(-e5 + 3 * e4 - 3 * e3 + e2);
        w_next[3] = WEIGHT_W'(e5 - 2 * e4 + e3);
        w_next[4] = WEIGHT_W'(2 * (-3 * e5 + 7 * e4 - 4 * e3));
        w_next[5] = WEIGHT_W'(2 * (6 * e5 - 15 * e4 + 10 * e3));
      end
      ORDER_D1: begin
        w_next[0] = WEIGHT_W'(2 * (-30 * e4 + 60 * e3 - 30 * e2));
        w_next[1] = WEIGHT_W'(2 * (-15 * e4 + 32 * e3 - 18 * e2) + 2 * one);
        w_next[2] = WEIGHT_W'(-5 * e4 + 12 * e3 - 9 * e2 + 2 * e1);
        w_next[3] = WEIGHT_W'(5 * e4 - 8 * e3 + 3 * e2);
        w_next[4] = WEIGHT_W'(2 * (-15 * e4 + 28 * e3 - 12 * e2));
        w_next[5] = WEIGHT_W'(2 * (30 * e4 - 60 * e3 + 30 * e2));
      end
      ORDER_D2: begin
        w_next[0] = WEIGHT_W'(2 * (-120 * e3 + 180 * e2 - 60 * e1));
        w_next[1] = WEIGHT_W'(2 * (-60 * e3 + 96 * e2 - 36 * e1));
        w_next[2] = WEIGHT_W'(2 * (-10 * e3 + 18 * e2 - 9 * e1 + one));
        w_next[3] = WEIGHT_W'(2 * (10 * e3 - 12 * e2 + 3 * e1));
        w_next[4] = WEIGHT_W'(2 * (-60 * e3 + 84 * e2 - 24 * e1));
        w_next[5] = WEIGHT_W'(2 * (120 * e3 - 180 * e2 + 60 * e1));
      end
      default: begin
        // unused order gives a zero result
        for (int i = 0; i < 6; i++) w_next[i] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < 6; i++) w[i] <= w_next[i];
    end
  end

  // weight times coordinate, weights in order p0 d1_0 d2_0 d2_1 d1_1 p1
  always_ff @(posedge clk) begin
    if (en[6]) begin
      px[0] <= w[0] * $signed(vec[0][COORD_WIDTH-1:0]);
      px[1] <= w[1] * $signed(vec[2][COORD_WIDTH-1:0]);
      px[2] <= w[2] * $signed(vec[4][COORD_WIDTH-1:0]);
      px[3] <= w[3] * $signed(vec[5][COORD_WIDTH-1:0]);
      px[4] <= w[4] * $signed(vec[3][COORD_WIDTH-1:0]);
      px[5] <= w[5] * $signed(vec[1][COORD_WIDTH-1:0]);
      py[0] <= w[0] * $signed(vec[0][2*COORD_WIDTH-1:COORD_WIDTH]);
      py[1] <= w[1] * $signed(vec[2][2*COORD_WIDTH-1:COORD_WIDTH]);
      py[2] <= w[2] * $signed(vec[4][2*COORD_WIDTH-1:COORD_WIDTH]);
      py[3] <= w[3] * $signed(vec[5][2*COORD_WIDTH-1:COORD_WIDTH]);
      py[4] <= w[4] * $signed(vec[3][2*COORD_WIDTH-1:COORD_WIDTH]);
      py[5] <= w[5] * $signed(vec[1][2*COORD_WIDTH-1:COORD_WIDTH]);
    end
  end

  // pairwise sums
  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int i = 0; i < 3; i++) begin
        hx[i] <= SUM_W'(px[2*i]) + SUM_W'(px[2*i+1]);
        hy[i] <= SUM_W'(py[2*i]) + SUM_W'(py[2*i+1]);
      end
    end
  end

  // full sums
  always_ff @(posedge clk) begin
    if (en[8]) begin
      sx <= hx[0] + hx[1] + hx[2];
      sy <= hy[0] + hy[1] + hy[2];
    end
  end

  // round half up to 16 fraction bits, then saturate
  assign qx = (sx + RND_ADD) >>> 17;
  assign qy = (sy + RND_ADD) >>> 17;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      priority if (qx > SAT_HI) ox <= SAT_HI[OUT_W-1:0];
      else if (qx < SAT_LO)     ox <= SAT_LO[OUT_W-1:0];
      else                      ox <= qx[OUT_W-1:0];
      priority if (qy > SAT_HI) oy <= SAT_HI[OUT_W-1:0];
      else if (qy < SAT_LO)     oy <= SAT_LO[OUT_W-1:0];
      else                      oy <= qy[OUT_W-1:0];
    end
  end

  assign result.valid = vld[NSTG-1];
  assign result.out_x = ox;
  assign result.out_y = oy;

  // checks on the datapath
  `QHE_ASSERT_NEXT(a_t_clamped, clk, rst, sample.valid && sample.ready && (sample.param_t > T_ONE), t1_a == T_ONE)
  `QHE_ASSERT_IMPL(a_t_range, clk, rst, vld[0], t1_a <= T_ONE)
  `QHE_ASSERT_IMPL(a_pow_order, clk, rst, vld[4], (t5_e <= t4_e) && (t4_e <= t3_e) && (t3_e <= t2_e) && (t2_e <= t1_e))
  `QHE_ASSERT_NEXT(a_none_zero, clk, rst, vld[4] && en[5] && (f_e == ORDER_NONE), (w[0] == '0) && (w[3] == '0) && (w[5] == '0))

endmodule

`default_nettype wire
